// ===== src/hptm_pkg.sv =====
// Shared types, constants and helper functions for the HDR pixel tone mapper.
// Depends on nothing; used by hptm_chan and hdr_pixel_tone_map_core.
`default_nettype none

package hptm_pkg;

  // Register stages from input capture to the output register.
  localparam int unsigned NUM_STAGES = 28;
  localparam int unsigned NUM_SQ     = 16;

  localparam logic signed [23:0] Q_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] Q_MIN = -24'sh800000;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SCALE = 2'd0;
  localparam logic [1:0] CFG_GAMMA = 2'd1;
  localparam logic [1:0] CFG_BG    = 2'd2;

  localparam logic [15:0] SCALE_RST = 16'd256;
  localparam logic [15:0] GAMMA_RST = 16'd14894;
  localparam logic [15:0] BG_RST    = 16'd0;

  // Polynomial coefficients for 2^f, Q16.
  localparam logic [15:0] EXP_C2 = 16'd5121;
  localparam logic [15:0] EXP_C1 = 16'd14823;
  localparam logic [15:0] EXP_C0 = 16'd45584;

  // Half-precision bit pattern to signed Q8.16, truncating and saturating.
  function automatic logic signed [23:0] half_to_q(input logic [15:0] h);
    logic [4:0]  e;
    logic [4:0]  eu;
    logic [10:0] sig;
    logic [31:0] mag;
    logic signed [23:0] res;
    e   = h[14:10];
    sig = (e != 5'd0) ? {1'b1, h[9:0]} : {1'b0, h[9:0]};
    eu  = (e == 5'd0) ? 5'd1 : e;
    if (eu >= 5'd9) begin
      mag = {21'd0, sig} << (eu - 5'd9);
    end else begin
      mag = {21'd0, sig} >> (5'd9 - eu);
    end
    if (e == 5'd31) begin
      if (h[9:0] != 10'd0) begin
        res = '0;
      end else begin
        res = h[15] ? Q_MIN : Q_MAX;
      end
    end else if (mag >= 32'h0080_0000) begin
      res = h[15] ? Q_MIN : Q_MAX;
    end else if (h[15]) begin
      res = ~{1'b0, mag[22:0]} + 24'd1;
    end else begin
      res = {1'b0, mag[22:0]};
    end
    return res;
  endfunction

  // Saturate a wide signed value to Q8.16.
  function automatic logic signed [23:0] sat_q(input logic signed [49:0] v);
    logic signed [23:0] res;
    if (v > 50'(Q_MAX)) begin
      res = Q_MAX;
    end else if (v < 50'(Q_MIN)) begin
      res = Q_MIN;
    end else begin
      res = v[23:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== src/hptm_chan.sv =====
// One colour channel of the tone mapper: decode, scale, composite, log2,
// gamma multiply and exp2. Uses hptm_pkg; stage enables come from the top level.
`default_nettype none

module hptm_chan (
  input  wire logic                             clk_i,
  input  wire logic [hptm_pkg::NUM_STAGES-1:0]  en_i,
  input  wire logic [15:0]                      half_i,
  input  wire logic signed [23:0]               alpha_i,
  input  wire logic [15:0]                      scale_i,
  input  wire logic [15:0]                      gamma_i,
  input  wire logic [15:0]                      bg_i,
  output logic [7:0]                            pix_o
);
  import hptm_pkg::*;

  logic signed [23:0] v0_q, a1_q, a2_q, v2_q, v3_q, v4_q;
  logic signed [40:0] p1_q;
  logic signed [47:0] pa_q;
  logic signed [45:0] pb_q;

  // Stage 0: decode.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      v0_q <= half_to_q(half_i);
    end
  end

  // Stage 1: exposure product.
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      p1_q <= v0_q * $signed({1'b0, scale_i});
      a1_q <= alpha_i;
    end
  end

  // Stage 2: truncate toward zero and saturate.
  logic signed [40:0] p1_rnd;
  assign p1_rnd = p1_q[40] ? (p1_q + 41'sd255) : p1_q;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      v2_q <= sat_q(50'(p1_rnd >>> 8));
      a2_q <= a1_q;
    end
  end

  // Stage 3: compositing products.
  logic signed [24:0] one_minus_a;
  assign one_minus_a = 25'sd65536 - 25'(a2_q);

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      pa_q <= a2_q * v2_q;
      pb_q <= one_minus_a * $signed({1'b0, bg_i, 4'b0000});
      v3_q <= v2_q;
    end
  end

  // Stage 4: composite sum, or the scaled value when the background is zero.
  logic signed [49:0] comp_sum, comp_rnd;
  assign comp_sum = 50'(pa_q) + 50'(pb_q);
  assign comp_rnd = comp_sum[49] ? (comp_sum + 50'sd65535) : comp_sum;

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      v4_q <= (bg_i != 16'd0) ? sat_q(comp_rnd >>> 16) : v3_q;
    end
  end

  // Stage 5: normalize to a mantissa in [1,2) as Q1.30.
  logic [4:0] msb;
  always_comb begin
    msb = '0;
    for (int b = 0; b < 23; b++) begin
      if (v4_q[b]) begin
        msb = 5'(b);
      end
    end
  end

  logic [30:0] y_q    [NUM_SQ+1];
  logic [15:0] frac_q [NUM_SQ+1];
  logic [4:0]  p_q    [NUM_SQ+1];
  logic        z_q    [NUM_SQ+1];

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      y_q[0]    <= {8'd0, v4_q[22:0]} << (5'd30 - msb);
      frac_q[0] <= '0;
      p_q[0]    <= msb;
      z_q[0]    <= v4_q[23] || (v4_q == 24'sd0);
    end
  end

  // Stages 6 to 21: one squaring per stage gives one fraction bit.
  for (genvar i = 0; i < NUM_SQ; i++) begin : g_sq
    logic [61:0] sq;
    assign sq = {31'd0, y_q[i]} * {31'd0, y_q[i]};
    always_ff @(posedge clk_i) begin
      if (en_i[6+i]) begin
        y_q[i+1]    <= sq[61] ? sq[61:31] : sq[60:30];
        frac_q[i+1] <= {frac_q[i][14:0], sq[61]};
        p_q[i+1]    <= p_q[i];
        z_q[i+1]    <= z_q[i];
      end
    end
  end

  // Stage 22: log2 times the inverse gamma.
  logic signed [21:0] lg;
  logic signed [5:0]  lg_int;
  assign lg_int = $signed({1'b0, p_q[NUM_SQ]}) - 6'sd16;
  assign lg     = {lg_int, frac_q[NUM_SQ]};

  logic signed [38:0] gp_q;
  logic               z22_q;
  always_ff @(posedge clk_i) begin
    if (en_i[22]) begin
      gp_q  <= lg * $signed({1'b0, gamma_i});
      z22_q <= z_q[NUM_SQ];
    end
  end

  // Stage 23: split into integer and fraction of the exponent.
  logic signed [38:0] gp_rnd;
  logic signed [23:0] r;
  logic signed [7:0]  n;
  logic [7:0]         s_full;
  assign gp_rnd = gp_q[38] ? (gp_q + 39'sd32767) : gp_q;
  assign r      = 24'(gp_rnd >>> 15);
  assign n      = r[23:16];
  assign s_full = 8'd16 - n;

  logic [15:0] f23_q;
  logic [5:0]  s23_q;
  logic        z23_q, sat23_q;
  always_ff @(posedge clk_i) begin
    if (en_i[23]) begin
      f23_q   <= r[15:0];
      s23_q   <= s_full[5:0];
      z23_q   <= z22_q;
      sat23_q <= !r[23];
    end
  end

  // Stages 24 to 26: Horner evaluation of 2^f.
  logic [31:0] h1, h2, h3;
  logic [14:0] t1_q;
  logic [15:0] t2_q;
  logic [16:0] m_q;
  logic [15:0] f24_q, f25_q;
  logic [5:0]  s24_q, s25_q, s26_q;
  logic        z24_q, z25_q, z26_q, sat24_q, sat25_q, sat26_q;

  assign h1 = {16'd0, EXP_C2} * {16'd0, f23_q};
  assign h2 = {17'd0, t1_q} * {16'd0, f24_q};
  assign h3 = {16'd0, t2_q} * {16'd0, f25_q};

  always_ff @(posedge clk_i) begin
    if (en_i[24]) begin
      t1_q    <= 15'(EXP_C1 + h1[31:16]);
      f24_q   <= f23_q;
      s24_q   <= s23_q;
      z24_q   <= z23_q;
      sat24_q <= sat23_q;
    end
    if (en_i[25]) begin
      t2_q    <= EXP_C0 + h2[31:16];
      f25_q   <= f24_q;
      s25_q   <= s24_q;
      z25_q   <= z24_q;
      sat25_q <= sat24_q;
    end
    if (en_i[26]) begin
      m_q     <= 17'h10000 + {1'b0, h3[31:16]};
      s26_q   <= s25_q;
      z26_q   <= z25_q;
      sat26_q <= sat25_q;
    end
  end

  // Stage 27: scale to 0..255.
  logic [24:0] m255, val;
  assign m255 = ({8'd0, m_q} << 8) - {8'd0, m_q};
  assign val  = m255 >> s26_q;

  always_ff @(posedge clk_i) begin
    if (en_i[27]) begin
      if (z26_q) begin
        pix_o <= 8'd0;
      end else if (sat26_q || (val > 25'd255)) begin
        pix_o <= 8'd255;
      end else begin
        pix_o <= val[7:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/hdr_pixel_tone_map_core.sv =====
// HDR pixel tone mapper; throughput one item per cycle while the output is not
// stalled. Each stage holds one item and moves on when the next stage is empty
// or moving, so bubbles are squeezed out under stall. The 16 squaring stages of
// the log2 set most of the depth.
// Reset clears valid bits and loads register defaults; no item is lost on stall.
`default_nettype none

module hdr_pixel_tone_map_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] red_in_i,
  input  wire logic [15:0] green_in_i,
  input  wire logic [15:0] blue_in_i,
  input  wire logic [15:0] alpha_in_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       red_out_o,
  output logic [7:0]       green_out_o,
  output logic [7:0]       blue_out_o,
  output logic [7:0]       alpha_out_o
);
  import hptm_pkg::*;

  logic [15:0] scale_q, gamma_q, bg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RST;
      gamma_q <= GAMMA_RST;
      bg_q    <= BG_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SCALE: scale_q <= cfg_data_i;
        CFG_GAMMA: gamma_q <= cfg_data_i;
        CFG_BG:    bg_q    <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  logic [NUM_STAGES-1:0] v_q;
  logic [NUM_STAGES:0]   en;

  assign en[NUM_STAGES] = !out_stall_i;
  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[NUM_STAGES-1];

  // Alpha decode and the alpha result, both formed at stage 0.
  logic signed [23:0] a_dec;
  logic [31:0]        a255;
  logic [7:0]         a_res;
  assign a_dec = half_to_q(alpha_in_i);
  assign a255  = ({9'd0, a_dec[22:0]} << 8) - {9'd0, a_dec[22:0]};

  always_comb begin
    if (bg_q != 16'd0) begin
      a_res = 8'd255;
    end else if (a_dec[23] || (a_dec == 24'sd0)) begin
      a_res = 8'd0;
    end else if (a255[31:16] > 16'd255) begin
      a_res = 8'd255;
    end else begin
      a_res = a255[23:16];
    end
  end

  logic signed [23:0] a0_q;
  logic [7:0]         ao_q [NUM_STAGES];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a0_q    <= a_dec;
      ao_q[0] <= a_res;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (en[k]) begin
        ao_q[k] <= ao_q[k-1];
      end
    end
  end

  assign alpha_out_o = ao_q[NUM_STAGES-1];

  hptm_chan u_red (
    .clk_i, .en_i(en[NUM_STAGES-1:0]), .half_i(red_in_i), .alpha_i(a0_q),
    .scale_i(scale_q), .gamma_i(gamma_q), .bg_i(bg_q), .pix_o(red_out_o)
  );

  hptm_chan u_green (
    .clk_i, .en_i(en[NUM_STAGES-1:0]), .half_i(green_in_i), .alpha_i(a0_q),
    .scale_i(scale_q), .gamma_i(gamma_q), .bg_i(bg_q), .pix_o(green_out_o)
  );

  hptm_chan u_blue (
    .clk_i, .en_i(en[NUM_STAGES-1:0]), .half_i(blue_in_i), .alpha_i(a0_q),
    .scale_i(scale_q), .gamma_i(gamma_q), .bg_i(bg_q), .pix_o(blue_out_o)
  );

  // The input is held off only when every stage is full and the output waits.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q) && out_stall_i)
    else $error("input stalled with a free stage");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> v_q[0])
    else $error("accepted item did not enter the first stage");

  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(red_out_o)
      && $stable(alpha_out_o))
    else $error("stalled result changed");

endmodule

`default_nettype wire
